/* sv/rro_pkg.sv */
// Shared types, angle constants and sine table generator for the rotated box overlap test.
`default_nettype none

package rro_pkg;

   localparam int FULL_TURN     = 360;
   localparam int THREE_QUARTER = 270;
   localparam int HALF_TURN     = 180;
   localparam int QUARTER_TURN  = 90;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // pi in unsigned Q30
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // Taylor series divisors (2k)(2k+1) for k = 1..8
   localparam logic [8:0] TAYLOR_DIV [1:8] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                              9'd110, 9'd156, 9'd210, 9'd272};

   typedef struct packed {
      logic [6:0] idx;
      logic       neg;
   } fold_type;

   typedef enum logic [1:0] {
      ORI_COLIN = 2'd0,
      ORI_CW    = 2'd1,
      ORI_CCW   = 2'd2
   } orient_type;

   // Sine magnitude of a first-quadrant angle, rounded to frac fractional bits.
   // Evaluated at elaboration only, to fill a constant table.
   function automatic logic [63:0] sin_mag(input logic [6:0] deg, input int frac);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      int          k;
      x    = (64'(deg) * PI_Q30) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k]);
         if (k[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return (sum + (64'd1 << (29 - frac))) >> (30 - frac);
   endfunction

endpackage

`default_nettype wire

/* sv/rotated_rectangle_overlap_test.sv */
// Top level of the rotated box pair overlap test.
//
// Usage: present two boxes (corner, width, height, angle in whole degrees)
// on the req_ channel; each transaction yields exactly one rsp_ transaction
// carrying rsp_overlap and rsp_edge_crossing, in order of acceptance.
// Angles of 360 and above wrap around once.
// Throughput: one transaction per cycle, sustained, on both channels while the receiver keeps rsp_ready high.
// Path: the accepting edge loads the angle fold and trig table front register;
// the item then passes through the two-entry queue, the back end registers
// (rotated corners, 64 orientation products, orientation codes) and the
// result register that holds the edge pair decision and drives rsp_valid.
// When the receiver stalls, the back end holds every stage; the queue and
// the front register then fill, and req_ready falls after that.
// Reset clears all valid state; no transaction is pending afterwards.
`default_nettype none

module rotated_rectangle_overlap_test #(
   parameter int COORD_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_a_left,
   input  wire logic signed [COORD_BITS-1:0] req_a_top,
   input  wire logic [11:0]                  req_a_width,
   input  wire logic [11:0]                  req_a_height,
   input  wire logic [8:0]                   req_a_angle,
   input  wire logic signed [COORD_BITS-1:0] req_b_left,
   input  wire logic signed [COORD_BITS-1:0] req_b_top,
   input  wire logic [11:0]                  req_b_width,
   input  wire logic [11:0]                  req_b_height,
   input  wire logic [8:0]                   req_b_angle,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_overlap,
   output logic                              rsp_edge_crossing
);
   import rro_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int T      = TRIG_FRAC_BITS + 2;
   localparam int ITEM_W = 2 * (2 * C + 24 + 2 * T);

   logic               fr_valid, fr_ready;
   logic [ITEM_W-1:0]  fr_data;
   logic               q_valid, q_ready;
   logic [ITEM_W-1:0]  q_data;

   logic signed [C-1:0] a_left, a_top, b_left, b_top;
   logic [11:0]         a_width, a_height, b_width, b_height;
   logic signed [T-1:0] a_sin, a_cos, b_sin, b_cos;

   rro_front #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
      .ITEM_W         (ITEM_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_a_left   (req_a_left),
      .req_a_top    (req_a_top),
      .req_a_width  (req_a_width),
      .req_a_height (req_a_height),
      .req_a_angle  (req_a_angle),
      .req_b_left   (req_b_left),
      .req_b_top    (req_b_top),
      .req_b_width  (req_b_width),
      .req_b_height (req_b_height),
      .req_b_angle  (req_b_angle),
      .item_valid   (fr_valid),
      .item_ready   (fr_ready),
      .item_data    (fr_data)
   );

   rro_fifo #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign {a_left, a_top, a_width, a_height, a_sin, a_cos,
           b_left, b_top, b_width, b_height, b_sin, b_cos} = q_data;

   rro_back #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (q_valid),
      .in_ready          (q_ready),
      .a_left            (a_left),
      .a_top             (a_top),
      .a_width           (a_width),
      .a_height          (a_height),
      .a_sin             (a_sin),
      .a_cos             (a_cos),
      .b_left            (b_left),
      .b_top             (b_top),
      .b_width           (b_width),
      .b_height          (b_height),
      .b_sin             (b_sin),
      .b_cos             (b_cos),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_overlap       (rsp_overlap),
      .rsp_edge_crossing (rsp_edge_crossing)
   );

endmodule

`default_nettype wire

/* sv/rro_fifo.sv */
// Two-entry queue between the classifying front end and the overlap back end.
`default_nettype none

module rro_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);
   import rro_pkg::*;

   logic [WIDTH-1:0]       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* sv/rro_front.sv */
// Front end: accepts a box pair, folds both angles and looks up sine and cosine.
`default_nettype none

module rro_front #(
   parameter int COORD_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 14,
   parameter int ITEM_W         = 2 * (2 * 16 + 24 + 2 * 16)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_a_left,
   input  wire logic signed [COORD_BITS-1:0] req_a_top,
   input  wire logic [11:0]                  req_a_width,
   input  wire logic [11:0]                  req_a_height,
   input  wire logic [8:0]                   req_a_angle,
   input  wire logic signed [COORD_BITS-1:0] req_b_left,
   input  wire logic signed [COORD_BITS-1:0] req_b_top,
   input  wire logic [11:0]                  req_b_width,
   input  wire logic [11:0]                  req_b_height,
   input  wire logic [8:0]                   req_b_angle,
   output logic                              item_valid,
   input  wire logic                         item_ready,
   output logic [ITEM_W-1:0]                 item_data
);
   import rro_pkg::*;

   localparam int F  = TRIG_FRAC_BITS;
   localparam int TM = F + 1;
   localparam int T  = F + 2;

   logic [TM-1:0]        sin_tab [0:QUARTER_TURN];
   logic [8:0]           ang [2];
   logic [9:0]           cos_ang [2];
   fold_type             sin_fold [2];
   fold_type             cos_fold [2];
   logic signed [T-1:0]  sin_val [2];
   logic signed [T-1:0]  cos_val [2];
   logic                 valid_ff;
   logic [ITEM_W-1:0]    data_ff, data_in;
   logic                 load;

   for (genvar g = 0; g <= QUARTER_TURN; g++) begin : g_sin
      assign sin_tab[g] = TM'(sin_mag(7'(g), F));
   end

   function automatic logic [8:0] wrap(input logic [9:0] d);
      logic [9:0] r;
      r = (d >= 10'(FULL_TURN)) ? 10'(d - 10'(FULL_TURN)) : d;
      return 9'(r);
   endfunction

   function automatic fold_type fold(input logic [8:0] d);
      fold_type r;
      r.neg = 1'b0;
      r.idx = 7'(d);
      if (d <= 9'(QUARTER_TURN)) begin
         r.idx = 7'(d);
      end else if (d <= 9'(HALF_TURN)) begin
         r.idx = 7'(9'(HALF_TURN) - d);
      end else if (d <= 9'(THREE_QUARTER)) begin
         r.idx = 7'(d - 9'(HALF_TURN));
         r.neg = 1'b1;
      end else begin
         r.idx = 7'(9'(FULL_TURN) - d);
         r.neg = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      ang[0] = wrap({1'b0, req_a_angle});
      ang[1] = wrap({1'b0, req_b_angle});
      for (int k = 0; k < 2; k++) begin
         cos_ang[k]  = {1'b0, ang[k]} + 10'(QUARTER_TURN);
         sin_fold[k] = fold(ang[k]);
         cos_fold[k] = fold(wrap(cos_ang[k]));
         sin_val[k]  = sin_fold[k].neg ? -$signed({1'b0, sin_tab[sin_fold[k].idx]})
                                       : $signed({1'b0, sin_tab[sin_fold[k].idx]});
         cos_val[k]  = cos_fold[k].neg ? -$signed({1'b0, sin_tab[cos_fold[k].idx]})
                                       : $signed({1'b0, sin_tab[cos_fold[k].idx]});
      end
      data_in = {req_a_left, req_a_top, req_a_width, req_a_height, sin_val[0], cos_val[0],
                 req_b_left, req_b_top, req_b_width, req_b_height, sin_val[1], cos_val[1]};
   end

   assign req_ready  = !valid_ff || item_ready;
   assign load       = req_valid && req_ready;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* sv/rro_back.sv */
// Back end: rotated corners, edge orientation tests, fallback extents check, result register.
`default_nettype none

module rro_back #(
   parameter int COORD_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire logic signed [COORD_BITS-1:0]       a_left,
   input  wire logic signed [COORD_BITS-1:0]       a_top,
   input  wire logic [11:0]                        a_width,
   input  wire logic [11:0]                        a_height,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]   a_sin,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]   a_cos,
   input  wire logic signed [COORD_BITS-1:0]       b_left,
   input  wire logic signed [COORD_BITS-1:0]       b_top,
   input  wire logic [11:0]                        b_width,
   input  wire logic [11:0]                        b_height,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]   b_sin,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]   b_cos,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_overlap,
   output logic                                    rsp_edge_crossing
);
   import rro_pkg::*;

   localparam int C = COORD_BITS;
   localparam int F = TRIG_FRAC_BITS;
   localparam int T = F + 2;
   localparam int R = T + 13;
   localparam int P = ((C > 14) ? C : 14) + F + 1;
   localparam int D = P + 1;
   localparam int M = 2 * D;
   localparam int V = M + 1;
   localparam int E = ((C > 13) ? C : 13) + 1;
   localparam logic signed [V-1:0] UNIT = V'(1) <<< (2 * F);

   logic adv;

   // stage 1: corners and fallback
   logic signed [C-1:0]  left [2];
   logic signed [C-1:0]  top [2];
   logic [11:0]          wid [2];
   logic [11:0]          hgt [2];
   logic signed [T-1:0]  sn [2];
   logic signed [T-1:0]  cs [2];
   logic signed [R-1:0]  wc [2];
   logic signed [R-1:0]  ws [2];
   logic signed [R-1:0]  hc [2];
   logic signed [R-1:0]  hs [2];
   logic signed [P-1:0]  lf [2];
   logic signed [P-1:0]  tf [2];
   logic signed [E-1:0]  el [2];
   logic signed [E-1:0]  et [2];
   logic signed [E-1:0]  er [2];
   logic signed [E-1:0]  eb [2];
   logic signed [P-1:0]  cx_in [2][4];
   logic signed [P-1:0]  cy_in [2][4];
   logic signed [P-1:0]  cx_ff [2][4];
   logic signed [P-1:0]  cy_ff [2][4];
   logic                 fb_in, fb1_ff, fb2_ff, fb3_ff;
   logic                 v1_ff, v2_ff, v3_ff;

   // stage 2: orientation products and on-segment flags
   logic signed [D-1:0]  dqy [2][4][4];
   logic signed [D-1:0]  drx [2][4][4];
   logic signed [D-1:0]  dqx [2][4][4];
   logic signed [D-1:0]  dry [2][4][4];
   logic signed [M-1:0]  m1_in [2][4][4];
   logic signed [M-1:0]  m2_in [2][4][4];
   logic signed [M-1:0]  m1_ff [2][4][4];
   logic signed [M-1:0]  m2_ff [2][4][4];
   logic                 on_in [2][4][4];
   logic                 on2_ff [2][4][4];
   logic                 on3_ff [2][4][4];

   // stage 3: orientation codes
   logic signed [V-1:0]  ov [2][4][4];
   orient_type           ori_in [2][4][4];
   orient_type           ori_ff [2][4][4];

   // stage 4: edge pair decision
   logic                 cross_any;
   logic                 out_valid_ff;
   logic                 overlap_ff, overlap_in;
   logic                 edge_ff;

   function automatic logic inside_pair(
      input logic signed [E-1:0] al, input logic signed [E-1:0] at,
      input logic signed [E-1:0] ar, input logic signed [E-1:0] ab,
      input logic signed [E-1:0] bl, input logic signed [E-1:0] bt,
      input logic signed [E-1:0] br, input logic signed [E-1:0] bb);
      logic rx;
      logic lx;
      logic by;
      logic ty;
      rx = (ar >= bl) && (ar <= br);
      lx = (al <= br) && (al >= bl);
      by = (ab <= bb) && (ab >= bt);
      ty = (at >= bt) && (at <= bb);
      return (rx || lx) && (by || ty);
   endfunction

   assign adv      = !out_valid_ff || rsp_ready;
   assign in_ready = adv;

   always_comb begin
      left[0] = a_left;  top[0] = a_top;  wid[0] = a_width;  hgt[0] = a_height;
      sn[0]   = a_sin;   cs[0]  = a_cos;
      left[1] = b_left;  top[1] = b_top;  wid[1] = b_width;  hgt[1] = b_height;
      sn[1]   = b_sin;   cs[1]  = b_cos;
      for (int k = 0; k < 2; k++) begin
         wc[k] = $signed({1'b0, wid[k]}) * cs[k];
         ws[k] = $signed({1'b0, wid[k]}) * sn[k];
         hc[k] = $signed({1'b0, hgt[k]}) * cs[k];
         hs[k] = $signed({1'b0, hgt[k]}) * sn[k];
         lf[k] = P'(left[k]) <<< F;
         tf[k] = P'(top[k]) <<< F;
         cx_in[k][0] = lf[k];
         cy_in[k][0] = tf[k];
         cx_in[k][1] = lf[k] + P'(wc[k]);
         cy_in[k][1] = tf[k] + P'(ws[k]);
         cx_in[k][2] = lf[k] + P'(wc[k]) - P'(hs[k]);
         cy_in[k][2] = tf[k] + P'(ws[k]) + P'(hc[k]);
         cx_in[k][3] = lf[k] - P'(hs[k]);
         cy_in[k][3] = tf[k] + P'(hc[k]);
         el[k] = E'(left[k]);
         et[k] = E'(top[k]);
         er[k] = el[k] + $signed(E'(wid[k]));
         eb[k] = et[k] + $signed(E'(hgt[k]));
      end
      fb_in = inside_pair(el[0], et[0], er[0], eb[0], el[1], et[1], er[1], eb[1]) ||
              inside_pair(el[1], et[1], er[1], eb[1], el[0], et[0], er[0], eb[0]);
   end

   // edge i of box e runs from corner i to corner i+1; r is corner j of the other box
   always_comb begin
      for (int e = 0; e < 2; e++) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               dqy[e][i][j] = D'(cy_ff[e][2'(i + 1)]) - D'(cy_ff[e][i]);
               drx[e][i][j] = D'(cx_ff[1 - e][j]) - D'(cx_ff[e][2'(i + 1)]);
               dqx[e][i][j] = D'(cx_ff[e][2'(i + 1)]) - D'(cx_ff[e][i]);
               dry[e][i][j] = D'(cy_ff[1 - e][j]) - D'(cy_ff[e][2'(i + 1)]);
               m1_in[e][i][j] = dqy[e][i][j] * drx[e][i][j];
               m2_in[e][i][j] = dqx[e][i][j] * dry[e][i][j];
               on_in[e][i][j] =
                  ((cx_ff[1 - e][j] <= cx_ff[e][i]) || (cx_ff[1 - e][j] <= cx_ff[e][2'(i + 1)])) &&
                  ((cx_ff[1 - e][j] >= cx_ff[e][i]) || (cx_ff[1 - e][j] >= cx_ff[e][2'(i + 1)])) &&
                  ((cy_ff[1 - e][j] <= cy_ff[e][i]) || (cy_ff[1 - e][j] <= cy_ff[e][2'(i + 1)])) &&
                  ((cy_ff[1 - e][j] >= cy_ff[e][i]) || (cy_ff[1 - e][j] >= cy_ff[e][2'(i + 1)]));
            end
         end
      end
   end

   // truncate toward zero: anything under one whole unit is colinear
   always_comb begin
      for (int e = 0; e < 2; e++) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               ov[e][i][j] = V'(m1_ff[e][i][j]) - V'(m2_ff[e][i][j]);
               if ((ov[e][i][j] > -UNIT) && (ov[e][i][j] < UNIT)) begin
                  ori_in[e][i][j] = ORI_COLIN;
               end else if (ov[e][i][j] < 0) begin
                  ori_in[e][i][j] = ORI_CCW;
               end else begin
                  ori_in[e][i][j] = ORI_CW;
               end
            end
         end
      end
   end

   always_comb begin
      cross_any = 1'b0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (((ori_ff[0][i][j] != ori_ff[0][i][2'(j + 1)]) &&
                 (ori_ff[1][j][i] != ori_ff[1][j][2'(i + 1)])) ||
                ((ori_ff[0][i][j] == ORI_COLIN) && on3_ff[0][i][j]) ||
                ((ori_ff[0][i][2'(j + 1)] == ORI_COLIN) && on3_ff[0][i][2'(j + 1)]) ||
                ((ori_ff[1][j][i] == ORI_COLIN) && on3_ff[1][j][i]) ||
                ((ori_ff[1][j][2'(i + 1)] == ORI_COLIN) && on3_ff[1][j][2'(i + 1)])) begin
               cross_any = 1'b1;
            end
         end
      end
      overlap_in = cross_any || fb3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   // hold every stage while the result waits
   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         fb1_ff     <= fb_in;
         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         on2_ff     <= on_in;
         fb2_ff     <= fb1_ff;
         ori_ff     <= ori_in;
         on3_ff     <= on2_ff;
         fb3_ff     <= fb2_ff;
         overlap_ff <= overlap_in;
         edge_ff    <= cross_any;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_overlap       = overlap_ff;
   assign rsp_edge_crossing = edge_ff;

endmodule

`default_nettype wire

/* tb/sv/rotated_rectangle_overlap_test_tb.sv */
// Self-checking testbench for the rotated box pair overlap test.
`timescale 1ns / 100ps

module rotated_rectangle_overlap_test_tb;

   localparam int          FRAC         = 14;
   localparam logic [63:0] PI_Q30_VAL   = 64'd3373259426;
   localparam int          RANDOM_ITEMS = 1730;
   localparam int          CALM_ITEMS   = 200;
   localparam int          STALL_CYCLES = 300;
   localparam int          IDLE_LIMIT   = 4000;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [11:0]        width;
      logic [11:0]        height;
      logic [8:0]         angle;
   } box_type;

   typedef struct {
      bit overlap;
      bit edge_crossing;
   } verdict_type;

   class overlap_scoreboard;
      verdict_type pending[$];
      int          errors;

      function new();
         errors = 0;
      endfunction

      // Q1.14 sine of whole degrees, first-quadrant Taylor series folded by symmetry
      function automatic longint sine_q(int unsigned deg);
         int unsigned       d;
         int unsigned       fold;
         bit                neg;
         longint unsigned   x;
         longint unsigned   x2;
         longint unsigned   term;
         longint unsigned   acc;
         longint unsigned   q;
         d   = deg % rro_pkg::FULL_TURN;
         neg = 0;
         if (d <= 90) fold = d;
         else if (d <= 180) fold = 180 - d;
         else if (d <= 270) begin
            fold = d - 180;
            neg  = 1;
         end else begin
            fold = 360 - d;
            neg  = 1;
         end
         x    = 64'(fold) * PI_Q30_VAL / 64'd180;
         x2   = (x * x) >> 30;
         term = x;
         acc  = x;
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
         end
         q = (acc + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function automatic void rotate_corners(box_type b, output longint cx[4],
                                             output longint cy[4]);
         longint sn;
         longint cs;
         longint lf;
         longint tf;
         longint w;
         longint h;
         sn = sine_q(int'(b.angle));
         cs = sine_q((int'(b.angle) % rro_pkg::FULL_TURN) + 90);
         lf = longint'(b.left) * (longint'(1) << FRAC);
         tf = longint'(b.top) * (longint'(1) << FRAC);
         w  = longint'(b.width);
         h  = longint'(b.height);
         cx[0] = lf;                   cy[0] = tf;
         cx[1] = lf + w * cs;          cy[1] = tf + w * sn;
         cx[2] = lf + w * cs - h * sn; cy[2] = tf + w * sn + h * cs;
         cx[3] = lf - h * sn;          cy[3] = tf + h * cs;
      endfunction

      function automatic rro_pkg::orient_type turn_of(longint px, longint py, longint qx,
                                                      longint qy, longint rx, longint ry);
         logic signed [127:0] dy1;
         logic signed [127:0] dx2;
         logic signed [127:0] dx1;
         logic signed [127:0] dy2;
         logic signed [127:0] v;
         logic signed [127:0] mag;
         dy1 = qy - py;
         dx2 = rx - qx;
         dx1 = qx - px;
         dy2 = ry - qy;
         v   = dy1 * dx2 - dx1 * dy2;
         mag = (v < 0) ? -v : v;
         // truncate to whole units: anything under one unit is colinear
         if (mag < (128'sd1 <<< (2 * FRAC))) return rro_pkg::ORI_COLIN;
         return (v < 0) ? rro_pkg::ORI_CCW : rro_pkg::ORI_CW;
      endfunction

      function automatic bit within_span(longint px, longint py, longint qx, longint qy,
                                         longint rx, longint ry);
         return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
                qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
      endfunction

      function automatic bit segments_meet(longint p1x, longint p1y, longint q1x,
                                           longint q1y, longint p2x, longint p2y,
                                           longint q2x, longint q2y);
         rro_pkg::orient_type o1;
         rro_pkg::orient_type o2;
         rro_pkg::orient_type o3;
         rro_pkg::orient_type o4;
         o1 = turn_of(p1x, p1y, q1x, q1y, p2x, p2y);
         o2 = turn_of(p1x, p1y, q1x, q1y, q2x, q2y);
         o3 = turn_of(p2x, p2y, q2x, q2y, p1x, p1y);
         o4 = turn_of(p2x, p2y, q2x, q2y, q1x, q1y);
         if (o1 != o2 && o3 != o4) return 1;
         if (o1 == rro_pkg::ORI_COLIN && within_span(p1x, p1y, p2x, p2y, q1x, q1y)) return 1;
         if (o2 == rro_pkg::ORI_COLIN && within_span(p1x, p1y, q2x, q2y, q1x, q1y)) return 1;
         if (o3 == rro_pkg::ORI_COLIN && within_span(p2x, p2y, p1x, p1y, q2x, q2y)) return 1;
         if (o4 == rro_pkg::ORI_COLIN && within_span(p2x, p2y, q1x, q1y, q2x, q2y)) return 1;
         return 0;
      endfunction

      // unrotated corner-in-box check of box p against box q, inclusive edges
      function automatic bit corner_inside(box_type p, box_type q);
         longint pl, pt, pr, pb, ql, qt, qr, qb;
         bit rx, lx, by, ty;
         pl = p.left; pt = p.top; pr = pl + p.width; pb = pt + p.height;
         ql = q.left; qt = q.top; qr = ql + q.width; qb = qt + q.height;
         rx = pr >= ql && pr <= qr;
         lx = pl <= qr && pl >= ql;
         by = pb <= qb && pb >= qt;
         ty = pt >= qt && pt <= qb;
         return (rx && by) || (rx && ty) || (lx && by) || (lx && ty);
      endfunction

      function automatic verdict_type judge_pair(box_type a, box_type b);
         longint      ax[4], ay[4], bx[4], by[4];
         verdict_type r;
         rotate_corners(a, ax, ay);
         rotate_corners(b, bx, by);
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               if (segments_meet(ax[i], ay[i], ax[(i + 1) % 4], ay[(i + 1) % 4],
                                 bx[j], by[j], bx[(j + 1) % 4], by[(j + 1) % 4])) begin
                  r.overlap       = 1;
                  r.edge_crossing = 1;
                  return r;
               end
            end
         end
         r.overlap       = corner_inside(a, b) || corner_inside(b, a);
         r.edge_crossing = 0;
         return r;
      endfunction

      function void note_request(box_type a, box_type b);
         pending = {pending, judge_pair(a, b)};
      endfunction

      function void check_response(bit overlap, bit edge_crossing);
         verdict_type e;
         if (pending.size() == 0) begin
            $error("unexpected response: overlap=%0d edge_crossing=%0d",
                   overlap, edge_crossing);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (overlap !== e.overlap) begin
            $error("overlap: expected %0d, actual %0d", e.overlap, overlap);
            errors++;
         end
         if (edge_crossing !== e.edge_crossing) begin
            $error("edge_crossing: expected %0d, actual %0d", e.edge_crossing, edge_crossing);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_a_left, req_a_top, req_b_left, req_b_top;
   logic [11:0]        req_a_width, req_a_height, req_b_width, req_b_height;
   logic [8:0]         req_a_angle, req_b_angle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_overlap;
   logic               rsp_edge_crossing;

   overlap_scoreboard  sb = new();
   bit                 sender_idles = 1;
   bit                 receiver_idles = 1;
   bit                 long_hold = 0;
   int                 idle_cycles = 0;

   rotated_rectangle_overlap_test u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_a_left        (req_a_left),
      .req_a_top         (req_a_top),
      .req_a_width       (req_a_width),
      .req_a_height      (req_a_height),
      .req_a_angle       (req_a_angle),
      .req_b_left        (req_b_left),
      .req_b_top         (req_b_top),
      .req_b_width       (req_b_width),
      .req_b_height      (req_b_height),
      .req_b_angle       (req_b_angle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_overlap       (rsp_overlap),
      .rsp_edge_crossing (rsp_edge_crossing)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_request('{req_a_left, req_a_top, req_a_width, req_a_height, req_a_angle},
                         '{req_b_left, req_b_top, req_b_width, req_b_height, req_b_angle});
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_overlap, rsp_edge_crossing);
      end
   end

   // watchdog: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            long_hold = 0;
            rsp_ready <= 1'b1;
         end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_pair(box_type a, box_type b);
      req_valid    <= 1'b1;
      req_a_left   <= a.left;
      req_a_top    <= a.top;
      req_a_width  <= a.width;
      req_a_height <= a.height;
      req_a_angle  <= a.angle;
      req_b_left   <= b.left;
      req_b_top    <= b.top;
      req_b_width  <= b.width;
      req_b_height <= b.height;
      req_b_angle  <= b.angle;
      do @(posedge clock); while (!req_ready);
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic box_type box(int l, int t, int w, int h, int ang);
      box_type b;
      b.left = 16'(l); b.top = 16'(t); b.width = 12'(w); b.height = 12'(h);
      b.angle = 9'(ang);
      return b;
   endfunction

   function automatic int pick_angle();
      unique case ($urandom_range(0, 9))
         0: return $urandom_range(360, 511);
         1: return 90 * $urandom_range(0, 3);
         default: return $urandom_range(0, 359);
      endcase
   endfunction

   function automatic int pick_size();
      unique case ($urandom_range(0, 15))
         0: return 0;
         1: return $urandom_range(0, 4095);
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   task automatic send_random();
      box_type a, b;
      int      l, t;
      if ($urandom_range(0, 4) == 0) begin
         // unconstrained content reaches every bit of every field
         a = box($urandom, $urandom, $urandom, $urandom, $urandom);
         b = box($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         // boxes near one another so both crossing and fallback paths are hit
         l = $urandom_range(0, 65535);
         t = $urandom_range(0, 65535);
         a = box(l, t, pick_size(), pick_size(), pick_angle());
         b = box(l + $urandom_range(0, 600) - 300, t + $urandom_range(0, 600) - 300,
                 pick_size(), pick_size(), pick_angle());
      end
      send_pair(a, b);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_a_left   = '0; req_a_top = '0; req_a_width = '0; req_a_height = '0;
      req_a_angle  = '0;
      req_b_left   = '0; req_b_top = '0; req_b_width = '0; req_b_height = '0;
      req_b_angle  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(box(0, 0, 0, 0, 0), box(0, 0, 0, 0, 0));
      send_pair(box(0, 0, 10, 10, 0), box(10, 0, 10, 10, 0));          // touching edges
      send_pair(box(0, 0, 100, 100, 0), box(20, 20, 10, 10, 0));        // nested
      send_pair(box(0, 0, 100, 100, 0), box(20, 20, 10, 10, 45));
      send_pair(box(0, 0, 10, 10, 0), box(500, 500, 10, 10, 0));        // far apart
      send_pair(box(-32768, -32768, 4095, 4095, 0), box(32767, 32767, 4095, 4095, 180));
      send_pair(box(32767, 32767, 4095, 4095, 359), box(-32768, -32768, 4095, 4095, 511));
      send_pair(box(0, 0, 50, 20, 90), box(-10, 10, 30, 30, 270));
      send_pair(box(0, 0, 50, 20, 360), box(0, 0, 50, 20, 0));          // wrapped angle
      send_pair(box(0, 0, 50, 20, 450), box(-5, 5, 10, 10, 135));
      send_pair(box(0, 0, 0, 40, 30), box(0, 0, 40, 0, 60));            // degenerate lines
      send_pair(box(5, 5, 0, 0, 0), box(0, 0, 10, 10, 0));              // point inside
      send_pair(box(5, 5, 0, 0, 77), box(20, 20, 0, 0, 200));
      send_pair(box(100, 100, 4095, 0, 225), box(-3000, -3000, 0, 4095, 315));
      send_pair(box(0, 0, 30, 30, 45), box(30, 30, 30, 30, 225));
      send_pair(box(-1, -1, 1, 1, 180), box(-2, -2, 1, 1, 270));
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400) long_hold = 1;
         if (i == 800) wait_drained();   // sender holds until all responses are in
         if (i == RANDOM_ITEMS - CALM_ITEMS) begin
            sender_idles   = 0;
            receiver_idles = 0;
         end
         send_random();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
